// ===== design/ple_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the positional list engine.
// No dependencies; the decoder, cell, top level and bench refer to this package.
package ple_pkg;

	typedef enum logic [2:0] {
		MODE_ADD_FIRST = 3'd0,
		MODE_ADD_LAST  = 3'd1,
		MODE_ADD_POS   = 3'd2,
		MODE_DEL_FIRST = 3'd3,
		MODE_DEL_LAST  = 3'd4,
		MODE_DEL_POS   = 3'd5,
		MODE_SEARCH    = 3'd6,
		MODE_NONE      = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_SEARCH = 2'd3
	} op_t;

	typedef struct packed {
		op_t     op;
		status_t status;
	} req_dec_t;

	typedef struct packed {
		op_t  op;
		logic upd;
		logic cap;
	} cell_cmd_t;

endpackage

// ===== design/ple_channels.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response words.
// Depends on nothing; used by the top level of the positional list engine.
interface ple_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic [6:0]         position;
	logic signed [31:0] item_value;

	modport source (output valid, output mode, output position, output item_value,
		input ready);
	modport sink (input valid, input mode, input position, input item_value,
		output ready);
endinterface

interface ple_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       found;
	logic [6:0] entry_count;

	modport source (output valid, output status, output found, output entry_count,
		input ready);
	modport sink (input valid, input status, input found, input entry_count,
		output ready);
endinterface

// ===== design/ple_decode.sv =====
`timescale 1ns / 1ps
// Request decoder: checks a request against the count and picks the cell operation.
// Depends on ple_pkg.
module ple_decode #(
	parameter int MAX_ENTRIES = 64,
	parameter int CW          = 7
) (
	input  logic [2:0]        mode,
	input  logic [6:0]        position,
	input  logic [CW-1:0]     count,
	output ple_pkg::req_dec_t dec,
	output logic [CW-1:0]     idx,
	output logic [CW-1:0]     next_count
);

	localparam int W = ((CW > 7) ? CW : 7) + 1;

	logic [W-1:0] pos_w;
	logic [W-1:0] cnt_w;
	logic         full;
	logic         empty;

	assign pos_w = W'(position);
	assign cnt_w = W'(count);
	assign full  = (count == CW'(MAX_ENTRIES));
	assign empty = (count == '0);

	always_comb begin
		dec.op     = ple_pkg::OP_HOLD;
		dec.status = ple_pkg::ST_OK;
		idx        = '0;
		next_count = count;
		case (ple_pkg::mode_t'(mode))
			ple_pkg::MODE_ADD_FIRST, ple_pkg::MODE_ADD_LAST, ple_pkg::MODE_ADD_POS: begin
				if (full) begin
					dec.status = ple_pkg::ST_FULL;
				end else if (ple_pkg::mode_t'(mode) == ple_pkg::MODE_ADD_POS &&
						(pos_w == '0 || pos_w > cnt_w + W'(1))) begin
					dec.status = ple_pkg::ST_BADPOS;
				end else begin
					dec.op     = ple_pkg::OP_INSERT;
					next_count = count + CW'(1);
					if (ple_pkg::mode_t'(mode) == ple_pkg::MODE_ADD_LAST) begin
						idx = count;
					end else if (ple_pkg::mode_t'(mode) == ple_pkg::MODE_ADD_POS) begin
						idx = CW'(pos_w - W'(1));
					end
				end
			end
			ple_pkg::MODE_DEL_FIRST, ple_pkg::MODE_DEL_LAST, ple_pkg::MODE_DEL_POS: begin
				if (empty) begin
					dec.status = ple_pkg::ST_EMPTY;
				end else if (ple_pkg::mode_t'(mode) == ple_pkg::MODE_DEL_POS &&
						(pos_w == '0 || pos_w > cnt_w)) begin
					dec.status = ple_pkg::ST_BADPOS;
				end else begin
					dec.op     = ple_pkg::OP_DELETE;
					next_count = count - CW'(1);
					if (ple_pkg::mode_t'(mode) == ple_pkg::MODE_DEL_LAST) begin
						idx = count - CW'(1);
					end else if (ple_pkg::mode_t'(mode) == ple_pkg::MODE_DEL_POS) begin
						idx = CW'(pos_w - W'(1));
					end
				end
			end
			ple_pkg::MODE_SEARCH: begin
				dec.op = ple_pkg::OP_SEARCH;
			end
			default: begin
				dec.op = ple_pkg::OP_HOLD;
			end
		endcase
	end

endmodule

// ===== design/ple_cell.sv =====
`timescale 1ns / 1ps
// One list slot: holds an entry, shifts with its neighbors and compares for search.
// Depends on ple_pkg.
module ple_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  logic                clk,
	input  ple_pkg::cell_cmd_t  cmd,
	input  logic [CW-1:0]       idx,
	input  logic [CW-1:0]       count,
	input  logic signed [31:0]  item_value,
	input  logic signed [31:0]  left,
	input  logic signed [31:0]  right,
	output logic signed [31:0]  entry,
	output logic                match_s1
);

	logic [CW-1:0]      here;
	logic signed [31:0] entry_q;
	logic signed [31:0] entry_d;
	logic               match_d;

	assign here  = CW'(IDX);
	assign entry = entry_q;

	always_comb begin
		entry_d = entry_q;
		case (cmd.op)
			ple_pkg::OP_INSERT: begin
				if (here == idx) begin
					entry_d = item_value;
				end else if (here > idx) begin
					entry_d = left;
				end
			end
			ple_pkg::OP_DELETE: begin
				if (here >= idx) begin
					entry_d = right;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	assign match_d = (cmd.op == ple_pkg::OP_SEARCH) && (here < count) &&
		(entry_q == item_value);

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			entry_q <= entry_d;
		end
		if (cmd.cap) begin
			match_s1 <= match_d;
		end
	end

endmodule

// ===== design/positional_list_engine.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Fields
// req      in   mode[2:0], position[6:0], item_value[31:0] signed
// rsp      out  status[1:0], found, entry_count[6:0]
//
// One request word is taken per cycle unless a stalled response backs up both stages.
// The row of cells shifts or compares every entry at acceptance; the per-cell match
// bits are registered and OR-reduced in the second stage into the output register.
// Reset clears the count and the pipeline valid bits; entries are not cleared.
// A stalled response holds the second stage; the first stage still takes one more word.
// Depends on ple_pkg, ple_channels, ple_decode and ple_cell.
module positional_list_engine #(
	parameter int MAX_ENTRIES = 64
) (
	input logic        clk,
	input logic        arst_n,
	ple_req_if.sink    req,
	ple_rsp_if.source  rsp
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	logic [CW-1:0]              count_q;
	logic [CW-1:0]              next_count;
	logic [CW-1:0]              idx;
	ple_pkg::req_dec_t          dec;
	ple_pkg::cell_cmd_t         cmd;
	logic signed [31:0]         entry [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]     match_s1;
	logic                       accept;
	logic                       s1_valid_q;
	logic                       s2_free;
	logic                       s1_adv;
	ple_pkg::status_t           status_s1;
	logic [CW-1:0]              count_s1;
	logic                       out_valid_q;
	ple_pkg::status_t           out_status_q;
	logic                       out_found_q;
	logic [6:0]                 out_count_q;

	ple_decode #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.CW(CW)
	) u_decode (
		.mode(req.mode),
		.position(req.position),
		.count(count_q),
		.dec(dec),
		.idx(idx),
		.next_count(next_count)
	);

	assign s2_free   = !out_valid_q || rsp.ready;
	assign s1_adv    = s1_valid_q && s2_free;
	assign req.ready = !s1_valid_q || s2_free;
	assign accept    = req.valid && req.ready;

	assign cmd.op  = dec.op;
	assign cmd.upd = accept && (dec.op == ple_pkg::OP_INSERT || dec.op == ple_pkg::OP_DELETE);
	assign cmd.cap = accept;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		ple_cell #(
			.IDX(i),
			.CW(CW)
		) u_cell (
			.clk(clk),
			.cmd(cmd),
			.idx(idx),
			.count(count_q),
			.item_value(req.item_value),
			.left((i == 0) ? req.item_value : entry[(i == 0) ? 0 : i - 1]),
			.right((i == MAX_ENTRIES - 1) ? entry[i] :
				entry[(i == MAX_ENTRIES - 1) ? i : i + 1]),
			.entry(entry[i]),
			.match_s1(match_s1[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= next_count;
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= dec.status;
			count_s1  <= next_count;
		end
		if (s1_adv) begin
			out_status_q <= status_s1;
			out_found_q  <= |match_s1;
			out_count_q  <= 7'(count_s1);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.found       = out_found_q;
	assign rsp.entry_count = out_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == $past(count_q) || count_q == $past(count_q) + CW'(1) ||
		count_q == $past(count_q) - CW'(1))
		else $error("entry count moved by more than one");

	a_reject_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && dec.status != ple_pkg::ST_OK |=> $stable(count_q))
		else $error("rejected request changed the count");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.found |-> rsp.status == ple_pkg::ST_OK)
		else $error("found reported with a failing status");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ready |=> out_valid_q)
		else $error("response word dropped while stalled");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for positional_list_engine: a directed table, then random requests.
// Depends on ple_pkg, ple_channels and the engine RTL; responses are predicted in-line.
module tb_top;

	localparam int LIST_DEPTH   = 64;
	localparam int RANDOM_WORDS = 1750;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 12;

	localparam int KIND_FILL  = 0;
	localparam int KIND_MIXED = 1;
	localparam int KIND_DRAIN = 2;

	typedef struct packed {
		ple_pkg::status_t status;
		logic             found;
		logic [6:0]       entry_count;
	} reply_t;

	typedef struct {
		ple_pkg::mode_t     mode;
		logic [6:0]         position;
		logic signed [31:0] value;
		logic               typed;
		reply_t             reply;
	} request_row_t;

	logic clk;
	logic arst_n;

	ple_req_if req_ch ();
	ple_rsp_if rsp_ch ();

	positional_list_engine #(.MAX_ENTRIES(LIST_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic signed [31:0] list_q[$];
	reply_t             replies_due[$];
	logic               row_typed;
	reply_t             row_reply;

	int errors;
	int words_sent;
	int words_seen;
	int search_hits;
	int peak_count;
	int status_tally[4];

	request_row_t directed_plan[24] = '{
		'{ple_pkg::MODE_SEARCH, 7'd0, 32'sd0, 1'b1, '{ple_pkg::ST_OK, 1'b0, 7'd0}},
		'{ple_pkg::MODE_DEL_FIRST, 7'd0, 32'sd0, 1'b1, '{ple_pkg::ST_EMPTY, 1'b0, 7'd0}},
		'{ple_pkg::MODE_DEL_LAST, 7'd0, 32'sd0, 1'b1, '{ple_pkg::ST_EMPTY, 1'b0, 7'd0}},
		'{ple_pkg::MODE_DEL_POS, 7'd5, 32'sd0, 1'b1, '{ple_pkg::ST_EMPTY, 1'b0, 7'd0}},
		'{ple_pkg::MODE_DEL_POS, 7'd0, 32'sd0, 1'b1, '{ple_pkg::ST_EMPTY, 1'b0, 7'd0}},
		'{ple_pkg::MODE_ADD_POS, 7'd0, 32'sd1, 1'b1, '{ple_pkg::ST_BADPOS, 1'b0, 7'd0}},
		'{ple_pkg::MODE_ADD_POS, 7'd2, 32'sd1, 1'b1, '{ple_pkg::ST_BADPOS, 1'b0, 7'd0}},
		'{ple_pkg::MODE_ADD_POS, 7'd1, 32'sh7fffffff, 1'b1, '{ple_pkg::ST_OK, 1'b0, 7'd1}},
		'{ple_pkg::MODE_ADD_FIRST, 7'd0, 32'sh80000000, 1'b1, '{ple_pkg::ST_OK, 1'b0, 7'd2}},
		'{ple_pkg::MODE_ADD_LAST, 7'd0, -32'sd1, 1'b1, '{ple_pkg::ST_OK, 1'b0, 7'd3}},
		'{ple_pkg::MODE_ADD_POS, 7'd4, 32'sd0, 1'b1, '{ple_pkg::ST_OK, 1'b0, 7'd4}},
		'{ple_pkg::MODE_ADD_POS, 7'd2, 32'sd5, 1'b0, '{ple_pkg::ST_OK, 1'b0, 7'd0}},
		'{ple_pkg::MODE_SEARCH, 7'd0, 32'sh80000000, 1'b1, '{ple_pkg::ST_OK, 1'b1, 7'd5}},
		'{ple_pkg::MODE_SEARCH, 7'd0, 32'sd12345, 1'b1, '{ple_pkg::ST_OK, 1'b0, 7'd5}},
		'{ple_pkg::MODE_SEARCH, 7'd0, 32'sd0, 1'b1, '{ple_pkg::ST_OK, 1'b1, 7'd5}},
		'{ple_pkg::MODE_NONE, 7'd127, -32'sd1, 1'b1, '{ple_pkg::ST_OK, 1'b0, 7'd5}},
		'{ple_pkg::MODE_DEL_POS, 7'd0, 32'sd0, 1'b1, '{ple_pkg::ST_BADPOS, 1'b0, 7'd5}},
		'{ple_pkg::MODE_DEL_POS, 7'd6, 32'sd0, 1'b1, '{ple_pkg::ST_BADPOS, 1'b0, 7'd5}},
		'{ple_pkg::MODE_ADD_POS, 7'd127, 32'sh55555555, 1'b1,
			'{ple_pkg::ST_BADPOS, 1'b0, 7'd5}},
		'{ple_pkg::MODE_DEL_POS, 7'd3, 32'sd0, 1'b0, '{ple_pkg::ST_OK, 1'b0, 7'd0}},
		'{ple_pkg::MODE_SEARCH, 7'd0, 32'sh7fffffff, 1'b0, '{ple_pkg::ST_OK, 1'b0, 7'd0}},
		'{ple_pkg::MODE_DEL_FIRST, 7'd0, 32'sd0, 1'b0, '{ple_pkg::ST_OK, 1'b0, 7'd0}},
		'{ple_pkg::MODE_DEL_LAST, 7'd0, 32'sd0, 1'b0, '{ple_pkg::ST_OK, 1'b0, 7'd0}},
		'{ple_pkg::MODE_ADD_POS, 7'd4, 32'shaaaaaaaa, 1'b1,
			'{ple_pkg::ST_BADPOS, 1'b0, 7'd2}}
	};

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic reply_t apply_request(input ple_pkg::mode_t mode,
			input logic [6:0] position, input logic signed [31:0] value);
		reply_t r;
		int     n;
		int     idx;
		n = list_q.size();
		r = '{ple_pkg::ST_OK, 1'b0, 7'd0};
		case (mode)
			ple_pkg::MODE_ADD_FIRST, ple_pkg::MODE_ADD_LAST, ple_pkg::MODE_ADD_POS: begin
				idx = (mode == ple_pkg::MODE_ADD_FIRST) ? 0 :
					(mode == ple_pkg::MODE_ADD_LAST) ? n : int'(position) - 1;
				if (n >= LIST_DEPTH)
					r.status = ple_pkg::ST_FULL;
				else if (idx < 0 || idx > n)
					r.status = ple_pkg::ST_BADPOS;
				else
					list_q.insert(idx, value);
			end
			ple_pkg::MODE_DEL_FIRST, ple_pkg::MODE_DEL_LAST, ple_pkg::MODE_DEL_POS: begin
				idx = (mode == ple_pkg::MODE_DEL_FIRST) ? 0 :
					(mode == ple_pkg::MODE_DEL_LAST) ? n - 1 : int'(position) - 1;
				if (n == 0)
					r.status = ple_pkg::ST_EMPTY;
				else if (idx < 0 || idx >= n)
					r.status = ple_pkg::ST_BADPOS;
				else
					list_q.delete(idx);
			end
			ple_pkg::MODE_SEARCH: begin
				foreach (list_q[i])
					if (list_q[i] == value)
						r.found = 1'b1;
			end
			default: ;
		endcase
		r.entry_count = 7'(list_q.size());
		return r;
	endfunction

	function automatic request_row_t draw_request(input int kind);
		request_row_t row;
		int           n;
		int           r;
		int           ins_pct;
		int           del_pct;
		n = list_q.size();
		ins_pct = (kind == KIND_FILL) ? 88 : (kind == KIND_DRAIN) ? 5 : 40;
		del_pct = (kind == KIND_FILL) ? 5 : (kind == KIND_DRAIN) ? 88 : 35;
		row.typed = 1'b0;
		row.reply = '0;
		r = $urandom_range(0, 99);
		if (r < 2)
			row.mode = ple_pkg::MODE_NONE;
		else if (r < 2 + ins_pct)
			row.mode = ple_pkg::mode_t'($urandom_range(0, 2));
		else if (r < 2 + ins_pct + del_pct)
			row.mode = ple_pkg::mode_t'($urandom_range(3, 5));
		else
			row.mode = ple_pkg::MODE_SEARCH;
		if ($urandom_range(0, 4) == 0)
			row.position = 7'($urandom_range(0, 127));
		else if (row.mode == ple_pkg::MODE_ADD_POS)
			row.position = 7'($urandom_range(1, n + 1));
		else if (row.mode == ple_pkg::MODE_DEL_POS && n > 0)
			row.position = 7'($urandom_range(1, n));
		else
			row.position = 7'($urandom_range(0, 127));
		case ($urandom_range(0, 9))
			0, 1, 2, 3: row.value = $urandom;
			4, 5, 6: row.value = int'($urandom_range(0, 16)) - 8;
			7: begin
				case ($urandom_range(0, 3))
					0: row.value = 32'sh80000000;
					1: row.value = 32'sh7fffffff;
					2: row.value = 32'sd0;
					default: row.value = -32'sd1;
				endcase
			end
			default: row.value = (n > 0) ? list_q[$urandom_range(0, n - 1)] : $urandom;
		endcase
		return row;
	endfunction

	function automatic int gap_length(input bit burst);
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 2);
		if (r < 97)
			return $urandom_range(3, 6);
		return $urandom_range(10, 30);
	endfunction

	task automatic send_word(input request_row_t row);
		req_ch.valid      <= 1'b1;
		req_ch.mode       <= row.mode;
		req_ch.position   <= row.position;
		req_ch.item_value <= row.value;
		row_typed         <= row.typed;
		row_reply         <= row.reply;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic hold_off(input int cycles);
		if (cycles > 0) begin
			req_ch.valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic wait_for_replies();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (replies_due.size() != 0);
		@(posedge clk);
	endtask

	always @(posedge clk) begin : scoreboard
		reply_t want;
		reply_t got;
		if (req_ch.valid && req_ch.ready) begin
			want = apply_request(ple_pkg::mode_t'(req_ch.mode), req_ch.position,
				req_ch.item_value);
			if (row_typed)
				want = row_reply;
			replies_due.push_back(want);
			words_sent++;
			if (list_q.size() > peak_count)
				peak_count = list_q.size();
		end
		if (rsp_ch.valid && rsp_ch.ready) begin
			got = '{ple_pkg::status_t'(rsp_ch.status), rsp_ch.found, rsp_ch.entry_count};
			words_seen++;
			if (replies_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected response word: status %0d found %0b count %0d",
					$time, got.status, got.found, got.entry_count);
			end else begin
				want = replies_due.pop_front();
				status_tally[want.status]++;
				if (want.found)
					search_hits++;
				if (got.status !== want.status) begin
					errors++;
					$display("%0t: status expected %0d, actual %0d",
						$time, want.status, got.status);
				end
				if (got.found !== want.found) begin
					errors++;
					$display("%0t: found expected %0b, actual %0b",
						$time, want.found, got.found);
				end
				if (got.entry_count !== want.entry_count) begin
					errors++;
					$display("%0t: entry_count expected %0d, actual %0d",
						$time, want.entry_count, got.entry_count);
				end
			end
		end
	end

	initial begin : sink_pacing
		int hold;
		int r;
		hold = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					rsp_ch.ready <= 1'b1;
					hold = $urandom_range(0, 7);
				end else if (r < 88) begin
					rsp_ch.ready <= 1'b0;
					hold = $urandom_range(0, 2);
				end else if (r < 96) begin
					rsp_ch.ready <= 1'b1;
					hold = $urandom_range(20, 60);
				end else begin
					rsp_ch.ready <= 1'b0;
					hold = $urandom_range(10, 40);
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out after %0d cycles with %0d responses outstanding.",
			cycles, replies_due.size());
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		request_row_t row;
		int           random_sent;
		int           seg;
		int           kind;
		int           len;
		bit           burst;
		errors = 0;
		words_sent = 0;
		words_seen = 0;
		search_hits = 0;
		peak_count = 0;
		status_tally = '{0, 0, 0, 0};
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode = ple_pkg::MODE_NONE;
		req_ch.position = '0;
		req_ch.item_value = '0;
		row_typed = 1'b0;
		row_reply = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[k]) begin
			send_word(directed_plan[k]);
			hold_off(gap_length(1'b0));
		end
		wait_for_replies();

		// Fill, mixed and drain phases take the list to full and back to empty repeatedly.
		random_sent = 0;
		seg = 0;
		while (random_sent < RANDOM_WORDS) begin
			case (seg % 4)
				0: kind = KIND_FILL;
				2: kind = KIND_DRAIN;
				default: kind = KIND_MIXED;
			endcase
			burst = ($urandom_range(0, 3) == 0);
			len = $urandom_range(80, 140);
			repeat (len) begin
				row = draw_request(kind);
				send_word(row);
				if (row.mode != ple_pkg::MODE_NONE)
					random_sent++;
				hold_off(gap_length(burst));
			end
			seg++;
			if (seg == 6)
				wait_for_replies();
		end

		wait_for_replies();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (replies_due.size() != 0) begin
			errors++;
			$display("%0t: %0d expected responses never arrived", $time, replies_due.size());
		end
		$display("Sent %0d request words (%0d random) and checked %0d responses; %0d errors.",
			words_sent, random_sent, words_seen, errors);
		$display("Status ok/empty/full/badpos %0d/%0d/%0d/%0d, search hits %0d, peak count %0d.",
			status_tally[0], status_tally[1], status_tally[2], status_tally[3],
			search_hits, peak_count);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
